[hdl/trme_pkg.sv]
// Shared types and constants of the tracker row MIDI emitter.
// Used by trme_front, trme_queue, trme_back and tracker_row_midi_emitter.
// No dependencies.
package trme_pkg;

  // item opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_BLOCK = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // register addresses
  localparam logic [2:0] ADDR_SPT  = 3'd0;
  localparam logic [19:0] SPT_RESET = 20'd4096;

  // MIDI status kinds, channel in the low nibble
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_CC       = 8'hB0;
  localparam logic [7:0] ST_PROG     = 8'hC0;
  localparam logic [7:0] ST_BEND     = 8'hE0;

  // parameter codes
  localparam logic [15:0] PAR_CC_BASE = 16'h3000;
  localparam logic [15:0] PAR_CC_END  = 16'h30FB;
  localparam logic [15:0] PAR_BEND    = 16'h30FE;

  localparam logic [7:0] CMD_MIDI    = 8'd9;
  localparam logic [7:0] NOTE_OFF    = 8'd255;
  localparam logic [7:0] DATA_MAX    = 8'h7F;
  localparam logic [6:0] VEL_DEFAULT = 7'd127;
  localparam logic [19:0] POS_MAX    = 20'hFFFFF;

  // x/255 for x < 2^28: q = (x * DIV_M) >> DIV_SH, exact
  localparam int unsigned DIV_SH = 36;
  localparam logic [28:0] DIV_M  = 29'd269488145;

  typedef enum logic {
    KIND_LIST,
    KIND_PROG
  } kind_e;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] d1;
    logic [7:0] d2;
  } msg_t;

  // one queued job: a list of up to four messages or a program-change burst
  typedef struct packed {
    kind_e           kind;
    logic [15:0]     ts_base;
    logic [2:0]      cnt;
    logic [6:0]      prog;
    msg_t [3:0]      msgs;
  } job_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  row_note;
    logic [6:0]  row_velocity;
    logic [7:0]  row_delay;
    logic [7:0]  row_command;
    logic [15:0] row_command_value;
    logic [15:0] row_parameter;
    logic [15:0] row_parameter_value;
    logic [4:0]  row_channel;
    logic [6:0]  row_program;
    logic [7:0]  present_mask;
    logic [15:0] block_samples;
  } item_t;

  typedef struct packed {
    logic [16:0] timestamp;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic        last_message;
  } out_t;

endpackage

[hdl/tracker_row_midi_emitter.sv]
// Tracker row MIDI emitter: one track turned into MIDI messages.
// Path: each job goes into a QDEPTH-entry queue, then its messages into the output
// register. Throughput: one item per cycle while the job queue has room; a tick with a
// delay stalls the input while the divide-by-255 multiply runs. Output: one message per
// cycle while the receiver is ready; a program burst is 16 messages and a firing up to 4.
// Reset: asynchronous, active low; clears track state, the tick length returns to 4096.
module tracker_row_midi_emitter #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // input stream
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // row_note, row_velocity, row_delay, row_command, row_command_value, row_parameter,
  // row_parameter_value, row_channel, row_program, present_mask, block_samples, 5 pad
  input  logic [119:0]  s_axis_tdata_i,
  // opcode
  input  logic [1:0]    s_axis_tuser_i,
  // output stream
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // timestamp, status_byte, data_one, data_two, 7 pad
  output logic [47:0]   m_axis_tdata_o,
  output logic          m_axis_tlast_o,
  // configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import trme_pkg::*;

  logic [19:0]                spt_q;
  item_t                      item;
  job_t                       push_job, head_job;
  logic                       q_push, q_pop, q_empty, q_full;
  logic                       div_busy;
  out_t                       out_msg;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SPT) ? {12'd0, spt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q <= SPT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_SPT)) begin
      spt_q <= pwdata[19:0];
    end
  end

  // unpack input item
  always_comb begin
    item.opcode              = s_axis_tuser_i;
    item.row_note            = s_axis_tdata_i[7:0];
    item.row_velocity        = s_axis_tdata_i[14:8];
    item.row_delay           = s_axis_tdata_i[22:15];
    item.row_command         = s_axis_tdata_i[30:23];
    item.row_command_value   = s_axis_tdata_i[46:31];
    item.row_parameter       = s_axis_tdata_i[62:47];
    item.row_parameter_value = s_axis_tdata_i[78:63];
    item.row_channel         = s_axis_tdata_i[83:79];
    item.row_program         = s_axis_tdata_i[90:84];
    item.present_mask        = s_axis_tdata_i[98:91];
    item.block_samples       = s_axis_tdata_i[114:99];
  end

  trme_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .spt_i      (spt_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .item_i     (item),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (push_job),
    .div_busy_o (div_busy)
  );

  trme_queue #(
    .Depth (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .pop_i   (q_pop),
    .head_o  (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  trme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (out_msg)
  );

  // pack output message
  assign m_axis_tdata_o = {7'd0, out_msg.data_two, out_msg.data_one,
                           out_msg.status_byte, out_msg.timestamp};
  assign m_axis_tlast_o = out_msg.last_message;

`ifndef SYNTH
  // a job is never offered to a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("job pushed into full queue");

  // a tick with a delay blocks the input while the divide finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == OP_TICK)
       && s_axis_tdata_i[92]) |=> (!s_axis_tready_o && div_busy))
    else $error("input accepted during delay divide");

  // the back end only pops a job that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

[hdl/trme_front.sv]
// Front end: accepts items, keeps the track state and turns items that produce messages into jobs.
// Depends on trme_pkg.
module trme_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [19:0]        spt_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  trme_pkg::item_t    item_i,
  input  logic               q_full_i,
  output logic               push_o,
  output trme_pkg::job_t     job_o,
  output logic               div_busy_o
);
  import trme_pkg::*;

  logic [7:0]  pending_q;
  logic [6:0]  held_vel_q;
  logic [19:0] fire_off_q;
  logic [7:0]  cmd_q;
  logic [15:0] cmdv_q;
  logic [15:0] par_q;
  logic [15:0] parv_q;
  logic [3:0]  flags_q;
  logic [3:0]  chan_q;
  logic [7:0]  sound_q;
  logic [19:0] pos_q;
  logic [27:0] prod_q;
  logic        div_busy_q;

  logic        accept;
  logic [20:0] blk_end;
  logic        fire_hit;
  logic [56:0] quot_full;
  logic [7:0]  parv_cl;
  logic        par_cc, par_bend, param_en;
  logic        cmd_both, cmd_cc, cmd_bend;
  logic [7:0]  cmd_x, cmd_y;
  logic        note_en, note_on;
  logic [7:0]  hi8, mn;
  logic [1:0]  idx;
  job_t        fire_job;
  job_t        tick_job;
  job_t        stop_job;

  assign in_ready_o = !div_busy_q && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign div_busy_o = div_busy_q;

  // firing window, both ends inclusive
  assign blk_end  = {1'b0, pos_q} + {5'b0, item_i.block_samples};
  assign fire_hit = (pos_q <= fire_off_q) && (blk_end >= {1'b0, fire_off_q});

  // second step of the delay scaling: divide by 255
  assign quot_full = 57'(prod_q) * 57'(DIV_M);

  // message classification
  assign parv_cl  = (parv_q > {8'd0, DATA_MAX}) ? DATA_MAX : parv_q[7:0];
  assign par_cc   = (par_q >= PAR_CC_BASE) && (par_q < PAR_CC_END);
  assign par_bend = (par_q == PAR_BEND);
  assign param_en = (flags_q[3:2] == 2'b11) && (par_cc || par_bend);
  assign cmd_both = (flags_q[1:0] == 2'b11);
  assign cmd_x    = cmdv_q[15:8];
  assign cmd_y    = cmdv_q[7:0];
  assign cmd_cc   = cmd_both && (cmd_q == CMD_MIDI) && !cmd_x[7];
  assign cmd_bend = cmd_both && (cmd_q == CMD_MIDI) && (cmd_x >= 8'hFE);
  assign note_en  = (pending_q != 8'd0);
  assign note_on  = note_en && (pending_q != NOTE_OFF);

  // MIDI note 12*octave + note - 1, modulo 256
  assign hi8 = {4'b0, pending_q[7:4]};
  assign mn  = (hi8 << 3) + (hi8 << 2) + {4'b0, pending_q[3:0]} - 8'd1;

  // pack the messages of one firing in order
  always_comb begin
    fire_job         = '0;
    fire_job.kind    = KIND_LIST;
    fire_job.ts_base = fire_off_q[19:4];
    idx              = 2'd0;
    if (param_en) begin
      fire_job.msgs[idx] = par_cc ?
          msg_t'{status: ST_CC | {4'b0, chan_q}, d1: 8'(par_q - PAR_CC_BASE), d2: parv_cl} :
          msg_t'{status: ST_BEND | {4'b0, chan_q}, d1: parv_cl, d2: 8'd0};
      idx          = idx + 2'd1;
      fire_job.cnt = fire_job.cnt + 3'd1;
    end
    if (cmd_cc || cmd_bend) begin
      fire_job.msgs[idx] = cmd_cc ?
          msg_t'{status: ST_CC | {4'b0, chan_q}, d1: cmd_x,
                 d2: (cmd_y > DATA_MAX) ? DATA_MAX : cmd_y} :
          msg_t'{status: ST_BEND | {4'b0, chan_q}, d1: cmd_x, d2: cmd_y};
      idx          = idx + 2'd1;
      fire_job.cnt = fire_job.cnt + 3'd1;
    end
    if (note_en) begin
      fire_job.msgs[idx] = '{status: ST_NOTE_OFF | {4'b0, chan_q}, d1: sound_q, d2: 8'd0};
      idx          = idx + 2'd1;
      fire_job.cnt = fire_job.cnt + 3'd1;
    end
    if (note_on) begin
      fire_job.msgs[idx] = '{status: ST_NOTE_ON | {4'b0, chan_q}, d1: mn,
                             d2: {1'b0, held_vel_q}};
      fire_job.cnt = fire_job.cnt + 3'd1;
    end
  end

  always_comb begin
    tick_job      = '0;
    tick_job.kind = KIND_PROG;
    tick_job.prog = item_i.row_program;
  end

  always_comb begin
    stop_job         = '0;
    stop_job.kind    = KIND_LIST;
    stop_job.cnt     = 3'd1;
    stop_job.msgs[0] = '{status: ST_NOTE_OFF | {4'b0, chan_q}, d1: sound_q, d2: 8'd0};
  end

  // job selection and push
  always_comb begin
    job_o  = fire_job;
    push_o = 1'b0;
    case (item_i.opcode)
      OP_TICK: begin
        job_o  = tick_job;
        push_o = accept && item_i.present_mask[7];
      end
      OP_BLOCK: begin
        job_o  = fire_job;
        push_o = accept && fire_hit && (fire_job.cnt != 3'd0);
      end
      OP_STOP: begin
        job_o  = stop_job;
        push_o = accept && (sound_q != 8'd0);
      end
      default: begin
        job_o  = fire_job;
        push_o = 1'b0;
      end
    endcase
  end

  // first step of the delay scaling
  always_ff @(posedge clk_i) begin
    if (accept && (item_i.opcode == OP_TICK) && item_i.present_mask[1]) begin
      prod_q <= 28'(spt_i) * 28'(item_i.row_delay);
    end
  end

  // track state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      held_vel_q <= VEL_DEFAULT;
      fire_off_q <= '0;
      cmd_q      <= '0;
      cmdv_q     <= '0;
      par_q      <= '0;
      parv_q     <= '0;
      flags_q    <= '0;
      chan_q     <= '0;
      sound_q    <= '0;
      pos_q      <= '0;
      div_busy_q <= 1'b0;
    end else begin
      if (div_busy_q) begin
        fire_off_q <= quot_full[DIV_SH+19:DIV_SH];
        div_busy_q <= 1'b0;
      end
      if (accept) begin
        case (item_i.opcode)
          OP_TICK: begin
            pos_q <= '0;
            if (item_i.row_note != 8'd0) begin
              pending_q  <= item_i.row_note;
              fire_off_q <= '0;
              held_vel_q <= VEL_DEFAULT;
            end
            if (item_i.present_mask[0]) held_vel_q <= item_i.row_velocity;
            if (item_i.present_mask[1]) div_busy_q <= 1'b1;
            if (item_i.present_mask[2]) begin
              cmd_q      <= item_i.row_command;
              flags_q[0] <= 1'b1;
            end
            if (item_i.present_mask[3]) begin
              cmdv_q     <= item_i.row_command_value;
              flags_q[1] <= 1'b1;
            end
            if (item_i.present_mask[4]) begin
              par_q      <= item_i.row_parameter;
              flags_q[2] <= 1'b1;
            end
            if (item_i.present_mask[5]) begin
              parv_q     <= item_i.row_parameter_value;
              flags_q[3] <= 1'b1;
            end
            if (item_i.present_mask[6]) chan_q <= item_i.row_channel[3:0] - 4'd1;
          end
          OP_BLOCK: begin
            if (fire_hit) begin
              if (cmd_both) begin
                flags_q[1:0] <= 2'b00;
                cmd_q        <= '0;
                cmdv_q       <= '0;
              end
              if (note_en) begin
                sound_q   <= note_on ? mn : 8'd0;
                pending_q <= '0;
              end
            end
            pos_q <= blk_end[20] ? POS_MAX : blk_end[19:0];
          end
          OP_STOP: begin
            if (sound_q != 8'd0) begin
              pending_q <= '0;
              sound_q   <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[hdl/trme_queue.sv]
// Short job queue between the front and back ends, built from flip-flops.
// Depends on trme_pkg.
module trme_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  trme_pkg::job_t               job_i,
  input  logic                         pop_i,
  output trme_pkg::job_t               head_o,
  output logic                         empty_o,
  output logic                         full_o
);
  import trme_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= job_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (!do_push && do_pop) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

[hdl/trme_back.sv]
// Back end: queued jobs become MIDI messages in an output register, one per ready cycle.
// Depends on trme_pkg.
module trme_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  trme_pkg::job_t   head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output trme_pkg::out_t   out_o
);
  import trme_pkg::*;

  logic [3:0] k_q;
  logic       ovalid_q;
  out_t       out_q;
  logic       load;
  logic       is_last;
  out_t       next_out;
  msg_t       cur;

  assign load = !empty_i && (!ovalid_q || out_ready_i);
  assign cur  = head_i.msgs[k_q[1:0]];

  // last message of the job at the head
  always_comb begin
    case (head_i.kind)
      KIND_PROG: is_last = (k_q == 4'd15);
      KIND_LIST: is_last = (k_q == 4'(head_i.cnt) - 4'd1);
      default:   is_last = 1'b1;
    endcase
  end

  // message at the current position
  always_comb begin
    next_out              = '0;
    next_out.last_message = is_last;
    case (head_i.kind)
      KIND_PROG: begin
        next_out.status_byte = ST_PROG | {4'b0, k_q};
        next_out.data_one    = {1'b0, head_i.prog};
      end
      default: begin
        next_out.timestamp   = 17'(head_i.ts_base) + 17'(k_q);
        next_out.status_byte = cur.status;
        next_out.data_one    = cur.d1;
        next_out.data_two    = cur.d2;
      end
    endcase
  end

  assign pop_o       = load && is_last;
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

  // output register
  always_ff @(posedge clk_i) begin
    if (load) out_q <= next_out;
  end

  // position within job, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        k_q      <= is_last ? 4'd0 : k_q + 4'd1;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

endmodule

[bench/tracker_row_midi_emitter_test.sv]
// Self-checking bench for tracker_row_midi_emitter: row, block and stop items are
// streamed in and every MIDI message out is checked against a track predictor.
// Depends on trme_pkg and the tracker_row_midi_emitter RTL.
`timescale 1ns / 1ps

module tracker_row_midi_emitter_test;
  import trme_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Predicts the MIDI messages of one track and holds those still due
  class midi_track_model;
    logic [19:0] spt;
    logic [7:0]  pend_note;
    logic [6:0]  vel;
    logic [19:0] fire_pos;
    logic [7:0]  cmd;
    logic [15:0] cmd_val;
    logic [15:0] par;
    logic [15:0] par_val;
    logic [3:0]  flags;
    logic [3:0]  chan;
    logic [7:0]  sound_note;
    logic [19:0] pos;
    out_t        midi_due[$];
    out_t        firing[$];
    int          fails;

    function new();
      spt = SPT_RESET;
      pend_note = 8'h00;
      vel = VEL_DEFAULT;
      fire_pos = '0;
      cmd = '0;
      cmd_val = '0;
      par = '0;
      par_val = '0;
      flags = '0;
      chan = '0;
      sound_note = '0;
      pos = '0;
      fails = 0;
    endfunction

    function void add_msg(logic [16:0] ts, logic [7:0] st, logic [7:0] d1, logic [7:0] d2);
      out_t m;
      m.timestamp = ts;
      m.status_byte = st;
      m.data_one = d1;
      m.data_two = d2;
      m.last_message = 1'b0;
      firing = {firing, m};
    endfunction

    // parameter message, command-9 message, note-off, note-on
    function void fire_track();
      logic [16:0] ts;
      logic [7:0]  ch;
      logic [7:0]  v;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  mn;
      int          t;
      ts = {1'b0, fire_pos[19:4]};
      ch = {4'h0, chan};
      if (flags[3:2] == 2'b11) begin
        v = (par_val > 16'd127) ? DATA_MAX : par_val[7:0];
        if (par >= PAR_CC_BASE && par < PAR_CC_END) begin
          add_msg(ts, ST_CC | ch, 8'(par - PAR_CC_BASE), v);
          ts++;
        end else if (par == PAR_BEND) begin
          add_msg(ts, ST_BEND | ch, v, 8'h00);
          ts++;
        end
      end
      if (flags[1:0] == 2'b11) begin
        if (cmd == CMD_MIDI) begin
          x = cmd_val[15:8];
          y = cmd_val[7:0];
          if (x <= DATA_MAX) begin
            add_msg(ts, ST_CC | ch, x, (y > DATA_MAX) ? DATA_MAX : y);
            ts++;
          end else if (x >= 8'hFE) begin
            add_msg(ts, ST_BEND | ch, x, y);
            ts++;
          end
        end
        flags[1:0] = 2'b00;
        cmd = '0;
        cmd_val = '0;
      end
      if (pend_note == 8'h00) return;
      // note-off goes out even with nothing sounding
      add_msg(ts, ST_NOTE_OFF | ch, sound_note, 8'h00);
      ts++;
      sound_note = 8'h00;
      if (pend_note != NOTE_OFF) begin
        t = 12 * int'(pend_note[7:4]) + int'(pend_note[3:0]) - 1;
        mn = t[7:0];
        add_msg(ts, ST_NOTE_ON | ch, mn, {1'b0, vel});
        sound_note = mn;
      end
      pend_note = 8'h00;
    endfunction

    // note one accepted item and queue the messages it causes
    function void take_row(item_t r);
      logic [63:0] prod;
      logic [20:0] stop_pos;
      firing.delete();
      case (r.opcode)
        OP_TICK: begin
          pos = '0;
          if (r.present_mask[7]) begin
            for (int i = 0; i < 16; i++)
              add_msg(17'd0, ST_PROG | 8'(i), {1'b0, r.row_program}, 8'h00);
          end
          if (r.row_note != 8'h00) begin
            pend_note = r.row_note;
            fire_pos = '0;
            vel = VEL_DEFAULT;
          end
          if (r.present_mask[0]) vel = r.row_velocity;
          if (r.present_mask[1]) begin
            prod = 64'(spt) * 64'(r.row_delay);
            fire_pos = 20'(prod / 64'd255);
          end
          if (r.present_mask[2]) begin
            cmd = r.row_command;
            flags[0] = 1'b1;
          end
          if (r.present_mask[3]) begin
            cmd_val = r.row_command_value;
            flags[1] = 1'b1;
          end
          if (r.present_mask[4]) begin
            par = r.row_parameter;
            flags[2] = 1'b1;
          end
          if (r.present_mask[5]) begin
            par_val = r.row_parameter_value;
            flags[3] = 1'b1;
          end
          if (r.present_mask[6]) chan = 4'(r.row_channel - 5'd1);
        end
        OP_BLOCK: begin
          // window is inclusive at both ends
          stop_pos = {1'b0, pos} + {5'b0, r.block_samples};
          if (pos <= fire_pos && stop_pos >= {1'b0, fire_pos}) fire_track();
          pos = (stop_pos > {1'b0, POS_MAX}) ? POS_MAX : stop_pos[19:0];
        end
        OP_STOP: begin
          if (sound_note != 8'h00) begin
            add_msg(17'd0, ST_NOTE_OFF | {4'h0, chan}, sound_note, 8'h00);
            pend_note = 8'h00;
            sound_note = 8'h00;
          end
        end
        default: ;
      endcase
      if (firing.size() > 0) firing[firing.size() - 1].last_message = 1'b1;
      midi_due = {midi_due, firing};
    endfunction

    // compare one transferred message with the oldest one due
    function void check_msg(out_t got);
      out_t want;
      if (midi_due.size() == 0) begin
        $error("unexpected message: timestamp %0d status %h data %h %h",
               got.timestamp, got.status_byte, got.data_one, got.data_two);
        fails++;
        return;
      end
      want = midi_due.pop_front();
      if (got.timestamp !== want.timestamp) begin
        $error("timestamp: expected %0d, got %0d", want.timestamp, got.timestamp);
        fails++;
      end
      if (got.status_byte !== want.status_byte) begin
        $error("status_byte: expected %h, got %h", want.status_byte, got.status_byte);
        fails++;
      end
      if (got.data_one !== want.data_one) begin
        $error("data_one: expected %h, got %h", want.data_one, got.data_one);
        fails++;
      end
      if (got.data_two !== want.data_two) begin
        $error("data_two: expected %h, got %h", want.data_two, got.data_two);
        fails++;
      end
      if (got.last_message !== want.last_message) begin
        $error("last_message: expected %b, got %b", want.last_message, got.last_message);
        fails++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_tvalid = 1'b0;
  logic          s_axis_tready_o;
  logic [119:0]  s_tdata = '0;
  logic [1:0]    s_tuser = '0;
  logic          m_axis_tvalid_o;
  logic          m_tready = 1'b0;
  logic [47:0]   m_axis_tdata_o;
  logic          m_axis_tlast_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  midi_track_model model = new();
  int              rows_sent = 0;
  int              burst_left = 0;
  int              rx_left = 0;
  bit              rx_ready = 1'b0;
  out_t            rx_msg;

  tracker_row_midi_emitter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: check each transfer, then pick the next ready or stall stretch
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      rx_msg.timestamp = m_axis_tdata_o[16:0];
      rx_msg.status_byte = m_axis_tdata_o[24:17];
      rx_msg.data_one = m_axis_tdata_o[32:25];
      rx_msg.data_two = m_axis_tdata_o[40:33];
      rx_msg.last_message = m_axis_tlast_o;
      model.check_msg(rx_msg);
    end
    if (rx_left > 0) begin
      rx_left--;
    end else begin
      rx_ready = !rx_ready;
      if (rx_ready)
        rx_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      else
        rx_left = $urandom_range(1, 6);
    end
    m_tready <= rx_ready;
  end

  function automatic item_t rand_row(logic [1:0] op);
    item_t r;
    r.opcode = op;
    r.row_note = 8'($urandom);
    r.row_velocity = 7'($urandom);
    r.row_delay = 8'($urandom);
    r.row_command = 8'($urandom);
    r.row_command_value = 16'($urandom);
    r.row_parameter = 16'($urandom);
    r.row_parameter_value = 16'($urandom);
    r.row_channel = 5'($urandom);
    r.row_program = 7'($urandom);
    r.present_mask = 8'($urandom);
    r.block_samples = 16'($urandom);
    return r;
  endfunction

  // one input transfer; bursts keep tvalid high, gaps drop it
  task automatic send_row(input item_t r);
    s_tvalid <= 1'b1;
    s_tuser <= r.opcode;
    s_tdata <= {5'd0, r.block_samples, r.present_mask, r.row_program, r.row_channel,
                r.row_parameter_value, r.row_parameter, r.row_command_value,
                r.row_command, r.row_delay, r.row_velocity, r.row_note};
    do @(posedge clk_i); while (!s_axis_tready_o);
    model.take_row(r);
    rows_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    end
  endtask

  // wait for every due message, then for the pipeline to empty
  task automatic drain();
    s_tvalid <= 1'b0;
    while (model.midi_due.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  // APB write of the tick length followed by a read-back
  task automatic set_spt(input logic [19:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SPT;
    pwdata <= {12'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    model.spt = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[19:0] !== val) begin
      $error("tick_len: expected %0d, got %0d", val, prdata[19:0]);
      model.fails++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly a tick followed by blocks that sweep the tick, sometimes noise
  task automatic run_sequence();
    item_t       r;
    int unsigned hi;
    int unsigned lo;
    int unsigned covered;
    int          nblk;
    int          pick;
    if ($urandom_range(0, 3) == 0) begin
      send_row(rand_row(2'($urandom)));
      return;
    end
    r = rand_row(OP_TICK);
    pick = $urandom_range(0, 9);
    if (pick < 2) r.row_note = 8'h00;
    else if (pick < 3) r.row_note = NOTE_OFF;
    else if (pick < 8) r.row_note = {4'($urandom_range(0, 10)), 4'($urandom_range(1, 12))};
    r.present_mask = r.present_mask & (($urandom_range(0, 5) == 0) ? 8'hFF : 8'h7F);
    pick = $urandom_range(0, 9);
    if (pick < 6) r.row_parameter = PAR_CC_BASE + 16'($urandom_range(0, 250));
    else if (pick < 8) r.row_parameter = PAR_BEND;
    if ($urandom_range(0, 1) == 1) r.row_parameter_value = 16'($urandom_range(0, 200));
    if ($urandom_range(0, 9) < 7) r.row_command = CMD_MIDI;
    pick = $urandom_range(0, 3);
    if (pick == 0) r.row_command_value[15:8] = 8'($urandom_range(0, 127));
    else if (pick == 1) r.row_command_value[15:8] = 8'($urandom_range(128, 253));
    else if (pick == 2) r.row_command_value[15:8] = 8'($urandom_range(254, 255));
    if ($urandom_range(0, 9) < 8) r.row_channel = 5'($urandom_range(1, 16));
    send_row(r);
    hi = model.spt / $urandom_range(1, 4) + 1;
    if (hi > 65535) hi = 65535;
    lo = hi / 2;
    covered = 0;
    nblk = 0;
    while (covered <= model.spt && nblk < 20) begin
      r = rand_row(OP_BLOCK);
      r.block_samples = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(lo, hi));
      send_row(r);
      covered += r.block_samples;
      nblk++;
    end
    if ($urandom_range(0, 4) == 0) send_row(rand_row(OP_STOP));
  endtask

  initial begin
    item_t       r;
    logic [19:0] spt_list[4];
    int          start;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: idle stop, unused opcode, all-zero tick, empty block
    send_row(rand_row(OP_STOP));
    r = '1;
    r.opcode = OP_UNUSED;
    send_row(r);
    r = '0;
    send_row(r);
    r = '0;
    r.opcode = OP_BLOCK;
    send_row(r);
    // full row: program burst, CC parameter, command-9 CC, delay of a whole tick
    r = rand_row(OP_TICK);
    r.row_note = 8'h45;
    r.present_mask = 8'hFF;
    r.row_velocity = 7'd0;
    r.row_delay = 8'd255;
    r.row_command = CMD_MIDI;
    r.row_command_value = 16'h7FFF;
    r.row_parameter = 16'h30FA;
    r.row_parameter_value = 16'hFFFF;
    r.row_channel = 5'd16;
    r.row_program = 7'd127;
    send_row(r);
    r = rand_row(OP_BLOCK);
    r.block_samples = 16'd0;
    send_row(r);
    r.block_samples = 16'd4096;
    send_row(r);
    r.block_samples = 16'hFFFF;
    send_row(r);
    send_row(rand_row(OP_STOP));
    // note off row with pitch bend parameter and 0xFE message, channel zero wraps
    r = rand_row(OP_TICK);
    r.row_note = NOTE_OFF;
    r.present_mask = 8'h7C;
    r.row_command = CMD_MIDI;
    r.row_command_value = 16'hFE80;
    r.row_parameter = PAR_BEND;
    r.row_parameter_value = 16'd5;
    r.row_channel = 5'd0;
    send_row(r);
    r = rand_row(OP_BLOCK);
    r.block_samples = 16'd1;
    send_row(r);
    // parameter below range, dropped user message
    r = rand_row(OP_TICK);
    r.row_note = 8'h1C;
    r.present_mask = 8'h1C;
    r.row_command = CMD_MIDI;
    r.row_command_value = 16'h8040;
    r.row_parameter = 16'h2FFF;
    send_row(r);
    r = rand_row(OP_BLOCK);
    r.block_samples = 16'd10;
    send_row(r);
    // odd note code, other command, parameter in the gap above CC range
    r = rand_row(OP_TICK);
    r.row_note = 8'h0F;
    r.present_mask = 8'h3E;
    r.row_delay = 8'd1;
    r.row_command = 8'd5;
    r.row_command_value = 16'hFFFF;
    r.row_parameter = PAR_CC_END;
    r.row_parameter_value = 16'd200;
    send_row(r);
    r = rand_row(OP_BLOCK);
    r.block_samples = 16'd16;
    send_row(r);
    // note zero nibble, command value without command, parameter above bend
    r = rand_row(OP_TICK);
    r.row_note = 8'hF0;
    r.present_mask = 8'h18;
    r.row_command_value = 16'hFF7F;
    r.row_parameter = 16'h30FF;
    send_row(r);
    r = rand_row(OP_BLOCK);
    r.block_samples = 16'd0;
    send_row(r);
    // command 9 with 0xFF message and no note, fired by the second block
    r = rand_row(OP_TICK);
    r.row_note = 8'h00;
    r.present_mask = 8'h07;
    r.row_velocity = 7'h55;
    r.row_delay = 8'd128;
    r.row_command = CMD_MIDI;
    send_row(r);
    r = rand_row(OP_BLOCK);
    r.block_samples = 16'd2000;
    send_row(r);
    r.block_samples = 16'd100;
    send_row(r);
    send_row(rand_row(OP_STOP));
    // channel 17 wraps; stop with a pending but silent note
    r = rand_row(OP_TICK);
    r.row_note = 8'h3C;
    r.present_mask = 8'h41;
    r.row_velocity = 7'd127;
    r.row_channel = 5'd17;
    send_row(r);
    send_row(rand_row(OP_STOP));
    r = rand_row(OP_BLOCK);
    r.block_samples = 16'd0;
    send_row(r);
    send_row(rand_row(OP_STOP));
    // all-ones tick and a full block
    r = '1;
    r.opcode = OP_TICK;
    send_row(r);
    r.opcode = OP_BLOCK;
    send_row(r);

    // random phases across tick lengths, extremes included
    spt_list[0] = 20'd1;
    spt_list[1] = POS_MAX;
    spt_list[2] = 20'($urandom_range(16, 8192));
    spt_list[3] = 20'($urandom_range(1, 20'hFFFFF));
    for (int p = 0; p < 4; p++) begin
      drain();
      set_spt(spt_list[p]);
      if (spt_list[p] == POS_MAX) begin
        // delay at the tick end: fires as the position saturates, then again
        r = rand_row(OP_TICK);
        r.row_note = 8'h45;
        r.row_delay = 8'd255;
        r.present_mask = 8'h32;
        r.row_parameter = PAR_CC_BASE;
        send_row(r);
        r = rand_row(OP_BLOCK);
        r.block_samples = 16'hFFFF;
        repeat (18) send_row(r);
      end
      start = rows_sent;
      while (rows_sent - start < 22) run_sequence();
    end

    drain();
    if (model.fails == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
hdl/trme_pkg.sv
hdl/trme_front.sv
hdl/trme_queue.sv
hdl/trme_back.sv
hdl/tracker_row_midi_emitter.sv
bench/tracker_row_midi_emitter_test.sv
